// ===== rtl/core/asde_pkg.sv =====
// Shared types and constants for the attack, sustain and decay envelope unit.
package asde_pkg;

	// Q2.14 volume and Q1.14 ratio formats
	localparam int unsigned LEVEL_W = 16;
	localparam int unsigned RATIO_W = 15;
	localparam int unsigned PUNCH_W = 16;
	localparam int unsigned PROD_W = RATIO_W + PUNCH_W;
	localparam logic [LEVEL_W-1:0] ONE_Q14 = 16'd16384;

	// restoring divider: one quotient bit per step, weights 2^14 down to 2^0
	localparam int unsigned DIV_STEPS = RATIO_W;
	localparam int unsigned DIV_CNT_W = 4;

	// register reset values
	localparam int unsigned ATTACK_RESET = 0;
	localparam int unsigned SUSTAIN_RESET = 9000;
	localparam int unsigned DECAY_RESET = 16000;

	// stream word widths
	localparam int unsigned S_DATA_W = 8;
	localparam int unsigned M_DATA_W = 24;

	localparam int unsigned CFG_IDX_W = 2;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_ATTACK_LENGTH  = 2'd0,
		CFG_SUSTAIN_LENGTH = 2'd1,
		CFG_DECAY_LENGTH   = 2'd2,
		CFG_PUNCH_GAIN     = 2'd3
	} cfg_index_t;

	typedef enum logic [1:0] {
		STAGE_ATTACK  = 2'd0,
		STAGE_SUSTAIN = 2'd1,
		STAGE_DECAY   = 2'd2,
		STAGE_DONE    = 2'd3
	} stage_t;

	typedef enum logic [5:0] {
		ST_IDLE  = 6'b000001,
		ST_INIT  = 6'b000010,
		ST_DIV   = 6'b000100,
		ST_MUL   = 6'b001000,
		ST_LEVEL = 6'b010000,
		ST_EMIT  = 6'b100000
	} ctrl_state_t;

	// controller to datapath
	typedef struct packed {
		logic tick;      // word accepted: restart or advance one sample
		logic div_load;  // load divider from count and stage length
		logic div_step;  // one quotient bit
		logic mul;       // register punch product
		logic level;     // recompute level
		logic emit;      // load output register
	} asde_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic stage_done;
		logic div_last;
		logic out_free;
	} asde_status_t;

endpackage

// ===== rtl/core/asde_ctrl.sv =====
// Sequencing state machine of the envelope unit.
module asde_ctrl
	import asde_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic         restart,
	input  asde_status_t status,
	output asde_cmd_t    cmd
);

	ctrl_state_t state_q;
	ctrl_state_t state_nxt;
	logic        accept;

	assign s_tready = (state_q == ST_IDLE);
	assign accept = s_tvalid && s_tready;

	// next state and commands
	always_comb begin
		state_nxt = state_q;
		cmd = '0;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					cmd.tick = 1'b1;
					if (restart || status.stage_done) begin
						state_nxt = ST_EMIT;
					end else begin
						state_nxt = ST_INIT;
					end
				end
			end
			ST_INIT: begin
				if (status.stage_done) begin
					state_nxt = ST_EMIT;
				end else begin
					cmd.div_load = 1'b1;
					state_nxt = ST_DIV;
				end
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				if (status.div_last) begin
					state_nxt = ST_MUL;
				end
			end
			ST_MUL: begin
				cmd.mul = 1'b1;
				state_nxt = ST_LEVEL;
			end
			ST_LEVEL: begin
				cmd.level = 1'b1;
				state_nxt = ST_EMIT;
			end
			ST_EMIT: begin
				if (status.out_free) begin
					cmd.emit = 1'b1;
					state_nxt = ST_IDLE;
				end
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	// hold state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

`ifndef NO_ASSERTIONS
	a_state_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot(state_q))
		else $error("controller state not one-hot");

	a_restart_skips_div: assert property (@(posedge clk) disable iff (!arst_n)
		accept && restart |=> state_q == ST_EMIT)
		else $error("restart word did not go straight to emit");

	a_div_to_mul: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DIV && status.div_last |=> state_q == ST_MUL)
		else $error("divider finish not followed by multiply");

	a_emit_waits: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_EMIT && !status.out_free |=> state_q == ST_EMIT && !cmd.tick)
		else $error("result dropped while output register full");
`endif

endmodule

// ===== rtl/core/asde_dp.sv =====
// Datapath of the envelope unit: registers, counter, divider, punch multiplier, output.
module asde_dp
	import asde_pkg::*;
#(
	parameter int unsigned LENGTH_BITS = 17
) (
	input  logic                                        clk,
	input  logic                                        arst_n,
	input  logic                                        cfg_we,
	input  logic [CFG_IDX_W-1:0]                        cfg_index,
	input  logic [((LENGTH_BITS > 16) ? LENGTH_BITS : 16)-1:0] cfg_data,
	input  logic                                        restart,
	input  asde_cmd_t                                   cmd,
	output asde_status_t                                status,
	output logic                                        m_tvalid,
	input  logic                                        m_tready,
	output logic [M_DATA_W-1:0]                         m_tdata
);

	logic [LENGTH_BITS-1:0] attack_len_q;
	logic [LENGTH_BITS-1:0] sustain_len_q;
	logic [LENGTH_BITS-1:0] decay_len_q;
	logic [PUNCH_W-1:0]     punch_q;

	logic [LENGTH_BITS-1:0] count_q;
	stage_t                 stage_q;
	logic [LEVEL_W-1:0]     level_q;

	logic [LENGTH_BITS:0]   rem_q;
	logic [LENGTH_BITS-1:0] divisor_q;
	logic                   div_zero_q;
	logic [DIV_CNT_W-1:0]   step_q;
	logic [RATIO_W-1:0]     quo_q;
	logic [PROD_W-1:0]      prod_q;

	logic                   out_valid_q;
	logic [M_DATA_W-1:0]    out_data_q;

	logic [LENGTH_BITS-1:0] len_cur;
	logic [LENGTH_BITS:0]   count_inc;
	logic [LENGTH_BITS:0]   trial;
	logic                   fits;
	logic [RATIO_W-1:0]     ratio_inv;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			attack_len_q <= LENGTH_BITS'(ATTACK_RESET);
			sustain_len_q <= LENGTH_BITS'(SUSTAIN_RESET);
			decay_len_q <= LENGTH_BITS'(DECAY_RESET);
			punch_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index_t'(cfg_index))
				CFG_ATTACK_LENGTH: attack_len_q <= cfg_data[LENGTH_BITS-1:0];
				CFG_SUSTAIN_LENGTH: sustain_len_q <= cfg_data[LENGTH_BITS-1:0];
				CFG_DECAY_LENGTH: decay_len_q <= cfg_data[LENGTH_BITS-1:0];
				CFG_PUNCH_GAIN: punch_q <= cfg_data[PUNCH_W-1:0];
				default: ;
			endcase
		end
	end

	// select current stage length
	always_comb begin
		case (stage_q)
			STAGE_ATTACK: len_cur = attack_len_q;
			STAGE_SUSTAIN: len_cur = sustain_len_q;
			default: len_cur = decay_len_q;
		endcase
	end

	assign count_inc = {1'b0, count_q} + (LENGTH_BITS+1)'(1);

	// sample counter, stage and level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			stage_q <= STAGE_ATTACK;
			level_q <= '0;
		end else if (cmd.tick) begin
			if (restart) begin
				count_q <= '0;
				stage_q <= STAGE_ATTACK;
				level_q <= '0;
			end else if (stage_q != STAGE_DONE) begin
				if (count_inc > {1'b0, len_cur}) begin
					count_q <= '0;
					stage_q <= stage_t'(stage_q + 2'd1);
				end else begin
					count_q <= count_inc[LENGTH_BITS-1:0];
				end
			end
		end else if (cmd.level) begin
			case (stage_q)
				STAGE_ATTACK: level_q <= LEVEL_W'(quo_q);
				STAGE_SUSTAIN: level_q <= ONE_Q14 + prod_q[PROD_W-1:RATIO_W];
				default: level_q <= ONE_Q14 - LEVEL_W'(quo_q);
			endcase
		end
	end

	// restoring divider: first step compares the count itself, later steps shift
	assign trial = (step_q == '0) ? rem_q : {rem_q[LENGTH_BITS-1:0], 1'b0};
	assign fits = !div_zero_q && (trial >= {1'b0, divisor_q});

	always_ff @(posedge clk) begin
		if (cmd.div_load) begin
			rem_q <= {1'b0, count_q};
			divisor_q <= len_cur;
			div_zero_q <= (len_cur == '0);
			quo_q <= '0;
		end else if (cmd.div_step) begin
			rem_q <= fits ? (trial - {1'b0, divisor_q}) : trial;
			quo_q <= {quo_q[RATIO_W-2:0], fits};
		end
	end

	// advance step count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= '0;
		end else if (cmd.div_load) begin
			step_q <= '0;
		end else if (cmd.div_step) begin
			step_q <= step_q + DIV_CNT_W'(1);
		end
	end

	// punch product (1 - r) * punch, later taken >> 15 for the doubled term
	assign ratio_inv = RATIO_W'(ONE_Q14) - quo_q;

	always_ff @(posedge clk) begin
		if (cmd.mul) begin
			prod_q <= PROD_W'(ratio_inv) * PROD_W'(punch_q);
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_data_q <= {5'd0, stage_q, (stage_q != STAGE_DONE), level_q};
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata = out_data_q;

	assign status.stage_done = (stage_q == STAGE_DONE);
	assign status.div_last = (step_q == DIV_CNT_W'(DIV_STEPS - 1));
	assign status.out_free = !out_valid_q || m_tready;

endmodule

// ===== rtl/core/attack_sustain_decay_envelope_unit.sv =====
// Top level of the attack, sustain and decay envelope unit.
//
// One input word is one sample tick (s_tdata[0] = 0) or a restart
// (s_tdata[0] = 1); each word yields exactly one output word carrying the
// Q2.14 volume, a playing flag and the stage. A tick in attack, sustain or
// decay goes from acceptance to the output register through the counter,
// the divider load, the bit-serial restoring divide that forms count/length
// in Q1.14, the punch multiply, the level and the output load. A restart
// or a tick after the decay stage has ended goes straight to the output
// load; the tick that ends the decay stage passes counter, stage check and
// output load. The next word is taken once the result is loaded into the
// output register, so the output may wait for its taker while the next word
// is processed. Lengths are written through cfg_we/cfg_index/cfg_data only
// while no word is in flight, a user rule that the block does not enforce.
module attack_sustain_decay_envelope_unit
	import asde_pkg::*;
#(
	parameter int unsigned LENGTH_BITS = 17
) (
	input  logic                                        clk,
	input  logic                                        arst_n,
	input  logic                                        cfg_we,
	input  logic [CFG_IDX_W-1:0]                        cfg_index,
	input  logic [((LENGTH_BITS > 16) ? LENGTH_BITS : 16)-1:0] cfg_data,
	input  logic                                        s_tvalid,
	output logic                                        s_tready,
	input  logic [S_DATA_W-1:0]                         s_tdata,  // [0] restart, rest zero
	output logic                                        m_tvalid,
	input  logic                                        m_tready,
	output logic [M_DATA_W-1:0]                         m_tdata   // [15:0] volume, [16] playing,
	                                                              // [18:17] phase, rest zero
);

	asde_cmd_t    cmd;
	asde_status_t status;

	// sequencer
	asde_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.restart  (s_tdata[0]),
		.status   (status),
		.cmd      (cmd)
	);

	// arithmetic and state
	asde_dp #(
		.LENGTH_BITS (LENGTH_BITS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.restart   (s_tdata[0]),
		.cmd       (cmd),
		.status    (status),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

endmodule
